// ----- rtl/zph_pkg.sv -----
// ----------------------------------------------------------------------------
// zph_pkg
// Shared types and constants of the Zobrist position hash block.
// ----------------------------------------------------------------------------
package zph_pkg;

  // key store layout
  localparam int NUM_KEYS    = 794;
  localparam int KEY_AW      = 10;
  localparam int SIDE_BASE   = 768;
  localparam int CASTLE_BASE = 770;
  localparam int EP_BASE     = 786;

  // splitmix64 constants
  localparam logic [63:0] SM_SEED   = 64'hC0D3_5B17_B04D_1234;
  localparam logic [63:0] SM_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MIX1   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MIX2   = 64'h94D0_49BB_1331_11EB;

  // default queue depths
  localparam int CMD_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    CMD_PIECE  = 2'd0,
    CMD_SIDE   = 2'd1,
    CMD_CASTLE = 2'd2,
    CMD_EP     = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    KG_ADD,
    KG_P0,
    KG_P1,
    KG_P2,
    KG_SUM,
    KG_DONE
  } kg_state_t;

  // key store write port
  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic [63:0]       data;
  } key_wr_t;

  // classified hash term
  typedef struct packed {
    logic              none;
    logic [KEY_AW-1:0] idx;
    logic              first;
    logic              last;
  } term_t;

endpackage

// ----- rtl/zph_fifo.sv -----
// ----------------------------------------------------------------------------
// zph_fifo
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
module zph_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/zph_keygen.sv -----
// ----------------------------------------------------------------------------
// zph_keygen
// splitmix64 key generator; fills the key store once after reset using one
// shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module zph_keygen
  import zph_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  output key_wr_t key_wr,
  output logic    fill_done
);

  kg_state_t         state_r, state_nxt;
  logic [63:0]       gen_r;
  logic [63:0]       gen_sum;
  logic [63:0]       x_r;
  logic [63:0]       p0_r;
  logic [31:0]       pc_r;
  logic [31:0]       p2_r;
  logic              round_r;
  logic [KEY_AW-1:0] fill_r;
  logic [63:0]       mix_c;
  logic              sel_a_hi;
  logic              sel_b_hi;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       y;

  assign gen_sum = gen_r + SM_GOLDEN;
  assign mix_c   = round_r ? SM_MIX2 : SM_MIX1;
  assign mul_a   = sel_a_hi ? x_r[63:32] : x_r[31:0];
  assign mul_b   = sel_b_hi ? mix_c[63:32] : mix_c[31:0];
  assign mul_p   = mul_a * mul_b;
  // low 64 bits of the full product from three partial products
  assign y       = p0_r + {pc_r + p2_r, 32'd0};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      KG_ADD: state_nxt = KG_P0;
      KG_P0:  state_nxt = KG_P1;
      KG_P1:  state_nxt = KG_P2;
      KG_P2:  state_nxt = KG_SUM;
      KG_SUM: begin
        if (!round_r) begin
          state_nxt = KG_P0;
        end else if (fill_r == KEY_AW'(NUM_KEYS-1)) begin
          state_nxt = KG_DONE;
        end else begin
          state_nxt = KG_ADD;
        end
      end
      KG_DONE: state_nxt = KG_DONE;
      default: state_nxt = KG_DONE;
    endcase
  end

  always_comb begin
    sel_a_hi    = 1'b0;
    sel_b_hi    = 1'b0;
    key_wr.en   = 1'b0;
    key_wr.addr = fill_r;
    key_wr.data = y ^ (y >> 31);
    fill_done   = 1'b0;
    case (state_r)
      KG_P1:   sel_b_hi  = 1'b1;
      KG_P2:   sel_a_hi  = 1'b1;
      KG_SUM:  key_wr.en = round_r;
      KG_DONE: fill_done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KG_ADD;
      gen_r   <= SM_SEED;
      round_r <= 1'b0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == KG_ADD) begin
        gen_r <= gen_sum;
      end
      if (state_r == KG_SUM) begin
        round_r <= ~round_r;
        if (round_r) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      KG_ADD: x_r  <= gen_sum ^ (gen_sum >> 30);
      KG_P0:  p0_r <= mul_p;
      KG_P1:  pc_r <= mul_p[31:0];
      KG_P2:  p2_r <= mul_p[31:0];
      KG_SUM: begin
        if (!round_r) begin
          x_r <= y ^ (y >> 27);
        end
      end
      default: ;
    endcase
  end

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    fill_done |=> fill_done)
    else $error("fill_done dropped after the fill");

  a_no_write_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr.en |-> !fill_done && (key_wr.addr < KEY_AW'(NUM_KEYS)))
    else $error("key store write outside the fill");

endmodule

// ----- rtl/zph_front.sv -----
// ----------------------------------------------------------------------------
// zph_front
// Accepts hash terms and maps each to a key store index.
// ----------------------------------------------------------------------------
module zph_front
  import zph_pkg::*;
(
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_command,
  input  logic [3:0] in_piece,
  input  logic [5:0] in_square,
  input  logic       in_white_to_move,
  input  logic [3:0] in_castling,
  input  logic [3:0] in_ep_file,
  input  logic       in_first,
  input  logic       in_last,
  input  logic       fill_done,
  input  logic       cq_full,
  output logic       cq_push,
  output term_t      cq_wdata
);

  assign in_full = !fill_done || cq_full;
  assign cq_push = in_push && !in_full;

  always_comb begin
    cq_wdata.first = in_first;
    cq_wdata.last  = in_last;
    cq_wdata.none  = 1'b0;
    cq_wdata.idx   = '0;
    case (cmd_e_t'(in_command))
      CMD_PIECE: begin
        cq_wdata.none = in_piece inside {[4'd12:4'd15]};
        cq_wdata.idx  = {in_piece, in_square};
      end
      CMD_SIDE: begin
        cq_wdata.idx = KEY_AW'(SIDE_BASE) + KEY_AW'(!in_white_to_move);
      end
      CMD_CASTLE: begin
        cq_wdata.idx = KEY_AW'(CASTLE_BASE) + KEY_AW'(in_castling);
      end
      CMD_EP: begin
        cq_wdata.none = in_ep_file[3];
        cq_wdata.idx  = KEY_AW'(EP_BASE) + KEY_AW'(in_ep_file[2:0]);
      end
      default: cq_wdata.none = 1'b1;
    endcase
  end

endmodule

// ----- rtl/zph_back.sv -----
// ----------------------------------------------------------------------------
// zph_back
// Key store, key lookup and running hash; queues finished hashes.
// ----------------------------------------------------------------------------
module zph_back
  import zph_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  key_wr_t     key_wr,
  input  logic        cq_empty,
  input  term_t       cq_rdata,
  output logic        cq_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_hash
);

  localparam int OCW = $clog2(OUT_DEPTH+1);

  logic [63:0]  key_mem [NUM_KEYS];
  logic [63:0]  rdata_r;
  logic         v1_r;
  logic         first1_r;
  logic         last1_r;
  logic         none1_r;
  logic [63:0]  hash_r, hash_nxt;
  logic         res_push;
  logic         res_full;
  logic [OCW-1:0] res_cnt;
  logic [OCW:0] committed;

  // reserve output space for every word in flight
  assign committed = {1'b0, res_cnt} + (OCW+1)'(v1_r);
  assign cq_pop    = !cq_empty && (committed < (OCW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (key_wr.en) begin
      key_mem[key_wr.addr] <= key_wr.data;
    end
    if (cq_pop) begin
      rdata_r <= key_mem[cq_rdata.idx];
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cq_rdata.first;
    last1_r  <= cq_rdata.last;
    none1_r  <= cq_rdata.none;
  end

  always_comb begin
    hash_nxt = first1_r ? 64'd0 : hash_r;
    if (!none1_r) begin
      hash_nxt = hash_nxt ^ rdata_r;
    end
  end

  assign res_push = v1_r && last1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      hash_r <= '0;
    end else begin
      v1_r <= cq_pop;
      if (v1_r) begin
        hash_r <= hash_nxt;
      end
    end
  end

  zph_fifo #(
    .WIDTH (64),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (hash_nxt),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_hash),
    .empty (out_empty),
    .count (res_cnt)
  );

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue overflow");

  a_lookup_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |=> v1_r)
    else $error("lookup stage lost a word");

endmodule

// ----- rtl/zobrist_position_hash.sv -----
// ----------------------------------------------------------------------------
// zobrist_position_hash
// Streaming Zobrist hash of a chess position: term lookup and XOR accumulate.
// ----------------------------------------------------------------------------
//  channel  | handshake           | word
//  ---------+---------------------+--------------------------------------------
//  in_      | in_push / in_full   | command, piece, square, white_to_move,
//           |                     | castling, ep_file, first, last
//  out_     | out_empty / out_pop | hash (64 bits, one per term with last set)
//
//  One term per cycle sustained while the result queue is drained; a hash
//  passes the term queue, the key store read and the XOR accumulate into the
//  result queue after its last term is accepted. After reset in_full stays
//  high for the key fill of 794 keys (one shared 32x32 multiplier).
//  A stalled out_pop fills the result queue, then the term queue, then in_full.
// ----------------------------------------------------------------------------
module zobrist_position_hash
  import zph_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_piece,
  input  logic [5:0]  in_square,
  input  logic        in_white_to_move,
  input  logic [3:0]  in_castling,
  input  logic [3:0]  in_ep_file,
  input  logic        in_first,
  input  logic        in_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_hash
);

  key_wr_t key_wr;
  logic    fill_done;
  logic    cq_push;
  logic    cq_full;
  logic    cq_pop;
  logic    cq_empty;
  term_t   cq_wdata;
  term_t   cq_rdata;
  logic [$clog2(CMD_DEPTH+1)-1:0] cq_count;

  zph_keygen u_keygen (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_wr    (key_wr),
    .fill_done (fill_done)
  );

  zph_front u_front (
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_piece         (in_piece),
    .in_square        (in_square),
    .in_white_to_move (in_white_to_move),
    .in_castling      (in_castling),
    .in_ep_file       (in_ep_file),
    .in_first         (in_first),
    .in_last          (in_last),
    .fill_done        (fill_done),
    .cq_full          (cq_full),
    .cq_push          (cq_push),
    .cq_wdata         (cq_wdata)
  );

  zph_fifo #(
    .WIDTH ($bits(term_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty),
    .count (cq_count)
  );

  zph_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_wr    (key_wr),
    .cq_empty  (cq_empty),
    .cq_rdata  (cq_rdata),
    .cq_pop    (cq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_hash  (out_hash)
  );

  a_no_terms_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_done |-> cq_empty && (cq_count == '0))
    else $error("term queued before the key fill finished");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the Zobrist position hash block.
// Builds its own copy of the key table, sends hash terms and checks each
// emitted hash. It starts with a directed table and then sends random
// position streams under several mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import zph_pkg::*;

  localparam int NUM_PIECES  = 12;
  localparam int NUM_FILES   = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PHASE = 382;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    cmd_e_t     cmd;
    logic [3:0] piece;
    logic [5:0] square;
    logic       wtm;
    logic [3:0] castling;
    logic [3:0] ep_file;
    logic       first;
    logic       last;
  } hash_term_t;

  typedef struct {
    hash_term_t  t;
    bit          known;
    logic [63:0] hash;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_command = '0;
  logic [3:0]  in_piece = '0;
  logic [5:0]  in_square = '0;
  logic        in_white_to_move = 1'b0;
  logic [3:0]  in_castling = '0;
  logic [3:0]  in_ep_file = '0;
  logic        in_first = 1'b0;
  logic        in_last = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [63:0] out_hash;

  logic [63:0] zkeys [NUM_KEYS];
  logic [63:0] pos_hash;
  logic [63:0] hash_due_q [$];
  dir_row_t    dir_rows [$];

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_cnt;
  int cycle_cnt;
  int mismatch_cnt;
  int term_cnt;
  int hash_cnt;

  always #6 clk = ~clk;

  zobrist_position_hash i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_piece         (in_piece),
    .in_square        (in_square),
    .in_white_to_move (in_white_to_move),
    .in_castling      (in_castling),
    .in_ep_file       (in_ep_file),
    .in_first         (in_first),
    .in_last          (in_last),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_hash         (out_hash)
  );

  function automatic logic [63:0] splitmix_out(logic [63:0] s);
    logic [63:0] z;
    z = s;
    z = (z ^ (z >> 30)) * SM_MIX1;
    z = (z ^ (z >> 27)) * SM_MIX2;
    return z ^ (z >> 31);
  endfunction

  function automatic void build_key_table();
    logic [63:0] s;
    s = SM_SEED;
    for (int k = 0; k < NUM_KEYS; k++) begin
      s = s + SM_GOLDEN;
      zkeys[k] = splitmix_out(s);
    end
  endfunction

  function automatic logic [63:0] term_key(hash_term_t t);
    logic [63:0] key;
    key = '0;
    case (t.cmd)
      CMD_PIECE: begin
        if (int'(t.piece) < NUM_PIECES) key = zkeys[int'(t.piece) * 64 + int'(t.square)];
      end
      CMD_SIDE: begin
        key = zkeys[SIDE_BASE + (t.wtm ? 0 : 1)];
      end
      CMD_CASTLE: begin
        key = zkeys[CASTLE_BASE + int'(t.castling)];
      end
      default: begin
        if (int'(t.ep_file) < NUM_FILES) key = zkeys[EP_BASE + int'(t.ep_file)];
      end
    endcase
    return key;
  endfunction

  function automatic void add_row(cmd_e_t c, int pc, int sq, int w, int cs, int ep,
                                  bit f, bit l, bit known, logic [63:0] h);
    dir_row_t r;
    r.t.cmd      = c;
    r.t.piece    = pc[3:0];
    r.t.square   = sq[5:0];
    r.t.wtm      = w[0];
    r.t.castling = cs[3:0];
    r.t.ep_file  = ep[3:0];
    r.t.first    = f;
    r.t.last     = l;
    r.known      = known;
    r.hash       = h;
    dir_rows.push_back(r);
  endfunction

  // well-formed term with random content; a few out-of-table codes mixed in
  function automatic hash_term_t rand_term(bit f, bit l);
    hash_term_t t;
    int         r;
    r = $urandom_range(0, 99);
    t.cmd      = (r < 55) ? CMD_PIECE : (r < 70) ? CMD_SIDE : (r < 85) ? CMD_CASTLE : CMD_EP;
    t.piece    = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, NUM_PIECES - 1))
                                               : 4'($urandom_range(NUM_PIECES, 15));
    t.square   = 6'($urandom_range(0, 63));
    t.wtm      = 1'($urandom_range(0, 1));
    t.castling = 4'($urandom_range(0, 15));
    t.ep_file  = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, NUM_FILES - 1))
                                               : 4'($urandom_range(NUM_FILES, 15));
    t.first    = f;
    t.last     = l;
    return t;
  endfunction

  function automatic hash_term_t noise_term();
    hash_term_t t;
    t = rand_term(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    t.cmd     = cmd_e_t'($urandom_range(0, 3));
    t.piece   = 4'($urandom_range(0, 15));
    t.ep_file = 4'($urandom_range(0, 15));
    return t;
  endfunction

  // called at a falling edge; returns at a falling edge after the word is taken
  task automatic push_word(input hash_term_t t, input bit known, input logic [63:0] typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push          <= 1'b1;
    in_command       <= t.cmd;
    in_piece         <= t.piece;
    in_square        <= t.square;
    in_white_to_move <= t.wtm;
    in_castling      <= t.castling;
    in_ep_file       <= t.ep_file;
    in_first         <= t.first;
    in_last          <= t.last;
    do @(posedge clk); while (in_full);
    term_cnt++;
    if (t.first) pos_hash = '0;
    pos_hash ^= term_key(t);
    if (t.last) hash_due_q.push_back(known ? typed : pos_hash);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (hash_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic send_position();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    // drop the last flag now and then to leave a broken sequence
    if ($urandom_range(0, 19) == 0) begin
      for (int i = 0; i < len; i++) push_word(rand_term(i == 0, 1'b0), 1'b0, '0);
    end else begin
      for (int i = 0; i < len; i++) push_word(rand_term(i == 0, i == len - 1), 1'b0, '0);
    end
  endtask

  // result side
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (hash_due_q.size() == 0) begin
        $display("%0t: unexpected hash word %h", $time, out_hash);
        mismatch_cnt++;
      end else begin
        if (out_hash !== hash_due_q[0]) begin
          $display("%0t: hash mismatch: expected %h, actual %h", $time, hash_due_q[0],
                   out_hash);
          mismatch_cnt++;
        end
        void'(hash_due_q.pop_front());
        hash_cnt++;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int sent;
    bit held;
    build_key_table();
    pos_hash       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    held           = 1'b0;

    // empty file or out-of-table piece adds nothing
    add_row(CMD_EP,     0,  0, 0,  0,  8, 1, 1, 1, 64'd0);
    add_row(CMD_PIECE, 12, 63, 0,  0,  0, 1, 1, 1, 64'd0);
    add_row(CMD_PIECE, 15,  0, 0,  0,  0, 1, 0, 0, '0);
    add_row(CMD_EP,     0,  0, 0,  0, 15, 0, 1, 1, 64'd0);
    // table corners
    add_row(CMD_PIECE,  0,  0, 0,  0,  0, 1, 1, 0, '0);
    add_row(CMD_PIECE, 11, 63, 0,  0,  0, 1, 1, 0, '0);
    add_row(CMD_SIDE,   0,  0, 1,  0,  0, 1, 1, 0, '0);
    add_row(CMD_SIDE,   0,  0, 0,  0,  0, 1, 1, 0, '0);
    add_row(CMD_CASTLE, 0,  0, 0,  0,  0, 1, 1, 0, '0);
    add_row(CMD_CASTLE, 0,  0, 0, 15,  0, 1, 1, 0, '0);
    add_row(CMD_EP,     0,  0, 0,  0,  0, 1, 1, 0, '0);
    add_row(CMD_EP,     0,  0, 0,  0,  7, 1, 1, 0, '0);
    // the same key twice cancels
    add_row(CMD_PIECE,  5, 36, 0,  0,  0, 1, 0, 0, '0);
    add_row(CMD_PIECE,  5, 36, 0,  0,  0, 0, 1, 1, 64'd0);
    // hash survives an emit
    add_row(CMD_PIECE,  3, 10, 0,  0,  0, 1, 1, 0, '0);
    add_row(CMD_PIECE,  3, 10, 0,  0,  0, 0, 1, 1, 64'd0);
    // fields the command does not select
    add_row(CMD_SIDE,  15, 63, 1, 15, 15, 1, 1, 0, '0);
    add_row(CMD_CASTLE, 9, 41, 1,  6, 12, 1, 1, 0, '0);
    add_row(CMD_EP,    15, 63, 1, 15, 15, 1, 1, 1, 64'd0);
    add_row(CMD_PIECE,  0,  0, 0,  0,  0, 0, 0, 0, '0);
    add_row(CMD_SIDE,   0,  0, 1,  0,  0, 0, 1, 0, '0);
    add_row(CMD_PIECE,  7, 21, 0,  3,  2, 0, 1, 0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) push_word(dir_rows[i].t, dir_rows[i].known, dir_rows[i].hash);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      sent = term_cnt;
      while (term_cnt - sent < ITEMS_PHASE) begin
        if (ph == 0 && !held && term_cnt - sent > ITEMS_PHASE / 2) begin
          // hold the result side and keep offering words until the input stalls
          held     = 1'b1;
          hold_req = 1'b1;
          for (int i = 0; i < 24; i++) push_word(rand_term(1'($urandom_range(0, 1)), 1'b1),
                                                 1'b0, '0);
        end else if ($urandom_range(0, 99) < 85) begin
          send_position();
        end else begin
          push_word(noise_term(), 1'b0, '0);
        end
      end
      drain_results();
    end

    while (hash_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d hash terms (directed table, position streams, noise); checked %0d hashes",
             term_cnt, hash_cnt);
    $display("under four idle/stall mixes, a long result hold-off and full drains between them");
    if (mismatch_cnt == 0 && hash_due_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/zph_pkg.sv
rtl/zph_fifo.sv
rtl/zph_keygen.sv
rtl/zph_front.sv
rtl/zph_back.sv
rtl/zobrist_position_hash.sv
tb/tb.sv
